/* rtl/per_ap_client_tracker_unit_defines.svh */
// Assertion macros for the per-AP client tracker.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef PER_AP_CLIENT_TRACKER_UNIT_DEFINES_SVH
`define PER_AP_CLIENT_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PACT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tracker check failed");

// Next-cycle implication, disabled during reset
`define PACT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tracker check failed");

`endif

/* rtl/pact_pkg.sv */
// Package for the per-AP client tracker: widths, command codes, result type.
// No dependencies; used by per_ap_client_tracker_unit.
`default_nettype none

package pact_pkg;

    localparam int AP_SLOTS_DEF       = 16;
    localparam int CLIENTS_PER_AP_DEF = 16;

    localparam int MAC_W       = 48;
    localparam int CMD_W       = 2;
    localparam int SLOT_OUT_W  = 4;
    localparam int COUNT_OUT_W = 5;

    localparam int IN_TDATA_W  = 2 * MAC_W;
    localparam int IN_TUSER_W  = CMD_W + 1;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SCAN  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_FRAME = 2'd2
    } cmd_t;

    typedef struct packed {
        logic                   accepted;
        logic [SLOT_OUT_W-1:0]  slot;
        logic                   fresh;
        logic [COUNT_OUT_W-1:0] count;
    } res_t;

endpackage

`default_nettype wire

/* rtl/pact_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/per_ap_client_tracker_unit.sv */
// Per-AP client tracker top level: AP table and client lists in two RAMs.
// Depends on pact_pkg, pact_ram and per_ap_client_tracker_unit_defines.svh.
`default_nettype none
`include "per_ap_client_tracker_unit_defines.svh"

// Tracks up to AP_SLOTS access points and, per AP, up to CLIENTS_PER_AP
// distinct client MACs. Every input item returns exactly one result item.
// Items are handled one at a time: a scan start, an ignored command or a full
// table goes from accept straight to the result state; an AP load passes
// through the load state first; an observed data frame that matches reads the
// AP entries up to and including the matching one, passes the client start
// state and then reads that AP's client entries (up to its count), since each
// RAM is searched through its single read port one entry per cycle. A data
// frame that matches no entry reads all loaded AP entries. A new item is taken
// the cycle after its predecessor's result is registered, even while that
// result waits on the output. Per-slot client counts live in the AP RAM beside
// the BSSID, with a valid bit per slot, so no clearing pass runs after reset.
module per_ap_client_tracker_unit #(
    parameter int AP_SLOTS       = pact_pkg::AP_SLOTS_DEF,
    parameter int CLIENTS_PER_AP = pact_pkg::CLIENTS_PER_AP_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write: retain_history
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic                             cfg_data,
    // input items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [pact_pkg::IN_TDATA_W-1:0]  s_tdata,  // bssid[47:0], source_mac[95:48]
    input  wire logic [pact_pkg::IN_TUSER_W-1:0]  s_tuser,  // cmd[1:0], frame_is_data[2]
    // result items
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [pact_pkg::OUT_TDATA_W-1:0] m_tdata,  // ap_slot[3:0], new_client[4],
                                                            // num_clients[9:5], zeros
    output logic      [pact_pkg::OUT_TUSER_W-1:0] m_tuser   // accepted[0]
);

    import pact_pkg::*;

    localparam int SW     = (AP_SLOTS > 1) ? $clog2(AP_SLOTS) : 1;
    localparam int TW     = $clog2(AP_SLOTS + 1);
    localparam int CW     = $clog2(CLIENTS_PER_AP + 1);
    localparam int JW     = (CLIENTS_PER_AP > 1) ? $clog2(CLIENTS_PER_AP) : 1;
    localparam int CDEPTH = AP_SLOTS * CLIENTS_PER_AP;
    localparam int CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int AP_W   = MAC_W + CW;
    localparam int PAD_W  = OUT_TDATA_W - SLOT_OUT_W - 1 - COUNT_OUT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_AP_SCAN,
        ST_CL_START,
        ST_CL_SCAN,
        ST_DONE
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic [TW-1:0]       ap_total_reg, ap_total_next;
    logic [AP_SLOTS-1:0] ap_valid_reg, ap_valid_next;
    logic                retain_reg, retain_next;
    logic                ov_reg, ov_next;

    // working payload
    logic [SW-1:0]    idx_reg, idx_next;
    logic [JW-1:0]    j_reg, j_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [CAW-1:0]   base_reg, base_next;
    logic [MAC_W-1:0] bssid_reg, bssid_next;
    logic [MAC_W-1:0] src_reg, src_next;
    res_t             res_reg, res_next;
    res_t             out_reg, out_next;

    // RAM ports
    logic             ap_wr_en, ap_rd_en;
    logic [SW-1:0]    ap_wr_addr, ap_rd_addr;
    logic [AP_W-1:0]  ap_wr_data, ap_rd_data;
    logic             cl_wr_en, cl_rd_en;
    logic [CAW-1:0]   cl_wr_addr, cl_rd_addr;
    logic [MAC_W-1:0] cl_wr_data, cl_rd_data;

    logic [TW:0]      idx_nx;
    logic [CW-1:0]    j_nx;
    logic [CW-1:0]    load_cnt;
    logic [CW-1:0]    ap_cnt;
    logic             ap_hit;
    logic             add_go;

    pact_ram #(
        .WIDTH (AP_W),
        .DEPTH (AP_SLOTS)
    ) u_ap_ram (
        .clk     (clk),
        .wr_en   (ap_wr_en),
        .wr_addr (ap_wr_addr),
        .wr_data (ap_wr_data),
        .rd_en   (ap_rd_en),
        .rd_addr (ap_rd_addr),
        .rd_data (ap_rd_data)
    );

    pact_ram #(
        .WIDTH (MAC_W),
        .DEPTH (CDEPTH)
    ) u_client_ram (
        .clk     (clk),
        .wr_en   (cl_wr_en),
        .wr_addr (cl_wr_addr),
        .wr_data (cl_wr_data),
        .rd_en   (cl_rd_en),
        .rd_addr (cl_rd_addr),
        .rd_data (cl_rd_data)
    );

    // Decode the word read from the AP RAM
    assign idx_nx   = (TW + 1)'(idx_reg) + (TW + 1)'(1);
    assign j_nx     = CW'(j_reg) + CW'(1);
    assign ap_hit   = (ap_rd_data[AP_W-1:CW] == bssid_reg);
    assign ap_cnt   = ap_valid_reg[idx_reg] ? ap_rd_data[CW-1:0] : '0;
    assign load_cnt = retain_reg ? ap_cnt : '0;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = ov_reg;
    assign m_tuser   = out_reg.accepted;
    assign m_tdata   = {{PAD_W{1'b0}}, out_reg.count, out_reg.fresh, out_reg.slot};

    // Sequence one item through the two RAMs
    always_comb
    begin
        state_next    = state_reg;
        ap_total_next = ap_total_reg;
        ap_valid_next = ap_valid_reg;
        retain_next   = retain_reg;
        ov_next       = ov_reg;
        idx_next      = idx_reg;
        j_next        = j_reg;
        n_next        = n_reg;
        base_next     = base_reg;
        bssid_next    = bssid_reg;
        src_next      = src_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        add_go        = 1'b0;

        ap_rd_en   = 1'b0;
        ap_rd_addr = idx_nx[SW-1:0];
        ap_wr_en   = 1'b0;
        ap_wr_addr = idx_reg;
        ap_wr_data = {bssid_reg, CW'(n_reg + 1'b1)};
        cl_rd_en   = 1'b0;
        cl_rd_addr = CAW'(base_reg + CAW'(j_nx));
        cl_wr_en   = 1'b0;
        cl_wr_addr = CAW'(base_reg + CAW'(n_reg));
        cl_wr_data = src_reg;

        if (cfg_valid)
        begin
            retain_next = cfg_data;
        end

        // drop the result once taken
        if (m_tready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    bssid_next = s_tdata[MAC_W-1:0];
                    src_next   = s_tdata[2*MAC_W-1:MAC_W];
                    res_next   = '0;
                    idx_next   = ap_total_reg[SW-1:0];
                    state_next = ST_DONE;
                    case (cmd_t'(s_tuser[CMD_W-1:0]))
                        CMD_SCAN:
                        begin
                            ap_total_next = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (ap_total_reg < TW'(AP_SLOTS))
                            begin
                                ap_rd_en   = 1'b1;
                                ap_rd_addr = ap_total_reg[SW-1:0];
                                state_next = ST_LOAD;
                            end
                        end
                        CMD_FRAME:
                        begin
                            if (s_tuser[CMD_W] && (ap_total_reg != '0))
                            begin
                                idx_next   = '0;
                                ap_rd_en   = 1'b1;
                                ap_rd_addr = '0;
                                state_next = ST_AP_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_LOAD:
            begin
                // store the BSSID with the kept or cleared count
                ap_wr_en               = 1'b1;
                ap_wr_data             = {bssid_reg, load_cnt};
                ap_valid_next[idx_reg] = 1'b1;
                ap_total_next          = TW'(ap_total_reg + 1'b1);
                res_next.accepted      = 1'b1;
                res_next.slot          = SLOT_OUT_W'(idx_reg);
                res_next.fresh         = 1'b0;
                res_next.count         = COUNT_OUT_W'(load_cnt);
                state_next             = ST_DONE;
            end

            ST_AP_SCAN:
            begin
                if (ap_hit)
                begin
                    n_next     = ap_cnt;
                    base_next  = CAW'(idx_reg * CLIENTS_PER_AP);
                    state_next = ST_CL_START;
                end
                else if (idx_nx < (TW + 1)'(ap_total_reg))
                begin
                    // advance; the next entry is read this cycle
                    ap_rd_en = 1'b1;
                    idx_next = idx_nx[SW-1:0];
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_CL_START:
            begin
                if (n_reg == '0)
                begin
                    add_go = 1'b1;
                end
                else
                begin
                    cl_rd_en   = 1'b1;
                    cl_rd_addr = base_reg;
                    j_next     = '0;
                    state_next = ST_CL_SCAN;
                end
            end

            ST_CL_SCAN:
            begin
                if (cl_rd_data == src_reg)
                begin
                    res_next.accepted = 1'b1;
                    res_next.slot     = SLOT_OUT_W'(idx_reg);
                    res_next.fresh    = 1'b0;
                    res_next.count    = COUNT_OUT_W'(n_reg);
                    state_next        = ST_DONE;
                end
                else if (j_nx < n_reg)
                begin
                    cl_rd_en = 1'b1;
                    j_next   = j_nx[JW-1:0];
                end
                else if (n_reg < CW'(CLIENTS_PER_AP))
                begin
                    add_go = 1'b1;
                end
                else
                begin
                    // list full: drop the address
                    res_next.accepted = 1'b1;
                    res_next.slot     = SLOT_OUT_W'(idx_reg);
                    res_next.fresh    = 1'b0;
                    res_next.count    = COUNT_OUT_W'(n_reg);
                    state_next        = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    out_next   = res_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Append a new client and bump the slot's count
        if (add_go)
        begin
            cl_wr_en          = 1'b1;
            ap_wr_en          = 1'b1;
            res_next.accepted = 1'b1;
            res_next.slot     = SLOT_OUT_W'(idx_reg);
            res_next.fresh    = 1'b1;
            res_next.count    = COUNT_OUT_W'(n_reg + 1'b1);
            state_next        = ST_DONE;
        end
    end

    // Hold state and the result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ap_total_reg <= '0;
            ap_valid_reg <= '0;
            retain_reg   <= 1'b1;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ap_total_reg <= ap_total_next;
            ap_valid_reg <= ap_valid_next;
            retain_reg   <= retain_next;
            ov_reg       <= ov_next;
        end
    end

    // Hold working payload and the result item
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        j_reg     <= j_next;
        n_reg     <= n_next;
        base_reg  <= base_next;
        bssid_reg <= bssid_next;
        src_reg   <= src_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    // Checks
    `PACT_ASSERT_IMP(a_total_bound, 1'b1, ap_total_reg <= TW'(AP_SLOTS))
    `PACT_ASSERT_IMP(a_scan_bound, state_reg == ST_AP_SCAN, (TW + 1)'(idx_reg) < (TW + 1)'(ap_total_reg))
    `PACT_ASSERT_IMP(a_reject_zero, m_tvalid && !m_tuser[0], m_tdata == '0)
    `PACT_ASSERT_NXT(a_accept_busy, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire
